// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Delayed implication.
`define ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("two-cycle check failed");

`endif

// File: rtl/core/ssir_pkg.sv
// Types and constants for the sorted set insert and rank block.
package ssir_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int VALUE_BITS  = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_CMP  = 1'b1
  } state_t;

  typedef struct packed {
    opcode_t opcode;
    value_t  value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    cnt_t       position;
    logic       exact_match;
    cnt_t       entry_count;
  } out_item_t;

  typedef struct packed {
    logic   cmp;
    logic   wr;
    value_t key;
  } ssir_cell_ctl_t;

endpackage

// File: rtl/core/ssir_cell.sv
// One table cell: holds an entry, compares it to the key, shifts up on insert.
module ssir_cell import ssir_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ssir_cell_ctl_t ctl,
  input  logic           valid_i,
  input  logic           prev_lt_i,
  input  value_t         prev_entry_i,
  output value_t         entry_o,
  output logic           lt_o,
  output logic           eq_o
);

  value_t entry_r;
  logic   lt_r;
  logic   eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      lt_r <= valid_i && (entry_r < ctl.key);
      eq_r <= valid_i && (entry_r == ctl.key);
    end
  end

  // at and above the insert point: the boundary cell takes the key, others the neighbor
  always_ff @(posedge clk) begin
    if (ctl.wr && !lt_r) begin
      entry_r <= prev_lt_i ? ctl.key : prev_entry_i;
    end
  end

  assign entry_o = entry_r;
  assign lt_o    = lt_r;
  assign eq_o    = eq_r;

endmodule

// File: rtl/core/sorted_set_insert_and_rank.sv
// Sorted set of distinct signed values with insert and rank query.
// In the accept cycle every cell compares its entry with the value; in the next
// cycle (busy high) the row of compare flags is encoded into the insert or rank
// position and, for an insert that is no duplicate and finds room, the cells at
// and above it shift up by one. The result is strobed on out_strobe for one cycle
// right after, while a new item may already be accepted; none is accepted while
// busy is high. The receiver cannot stall: every result must be taken in its
// strobe cycle. The table needs no clearing pass after reset; entries are not reset.
module sorted_set_insert_and_rank import ssir_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  state_t         state_r, state_nxt;
  opcode_t        op_r;
  value_t         key_r;
  cnt_t           count_r, count_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  out_item_t      out_r, out_nxt;
  ssir_cell_ctl_t ctl;
  logic           accept;

  logic   [TABLE_DEPTH-1:0] lt;
  logic   [TABLE_DEPTH-1:0] eq;
  logic   [TABLE_DEPTH-1:0] valid;
  value_t                   entry [TABLE_DEPTH];
  logic   [TABLE_DEPTH:0]   bnd;
  cnt_t                     lb;
  logic                     equal;
  logic                     full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    ctl.cmp = accept;
    ctl.key = (state_r == S_IDLE) ? in_data.value : key_r;
    ctl.wr  = (state_r == S_CMP) && (op_r == OP_INSERT) && !equal && !full;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid[i] = (CNT_W'(i) < count_r);
    ssir_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .valid_i      (valid[i]),
      .prev_lt_i    ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .prev_entry_i ((i == 0) ? key_r : entry[(i == 0) ? 0 : i-1]),
      .entry_o      (entry[i]),
      .lt_o         (lt[i]),
      .eq_o         (eq[i])
    );
  end

  // lt is a thermometer over the row; its edge marks the lower bound
  always_comb begin
    bnd[0] = !lt[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      bnd[i] = lt[i-1] && !lt[i];
    end
    bnd[TABLE_DEPTH] = lt[TABLE_DEPTH-1];
    lb    = '0;
    equal = 1'b0;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      if (bnd[i]) lb = lb | CNT_W'(i);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      equal = equal | (bnd[i] & eq[i]);
    end
    full = (count_r == CNT_W'(TABLE_DEPTH));
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt           = S_IDLE;
        out_strobe_nxt      = 1'b1;
        out_nxt.status      = ST_DONE;
        out_nxt.position    = '0;
        out_nxt.exact_match = 1'b0;
        if (op_r == OP_INSERT) begin
          out_nxt.position = lb;
          priority if (equal) begin
            out_nxt.status = ST_DUP;
          end else if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (count_r != '0) begin
          if (equal) begin
            out_nxt.position    = lb;
            out_nxt.exact_match = 1'b1;
          end else begin
            out_nxt.position = (lb == '0) ? '0 : lb - CNT_W'(1);
            if ((lb == '0) || (lb == count_r)) out_nxt.status = ST_RANGE;
          end
        end
        out_nxt.entry_count = count_nxt;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      op_r  <= in_data.opcode;
      key_r <= in_data.value;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// File: rtl/core/ssir_checker.sv
// Port-level checker for the sorted set block, bound to the top level.
`include "assert_macros.svh"

module ssir_checker import ssir_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_data
);

  `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, start && !busy, busy)
  `ASSERT_DELAY2(a_result_latency, clk, rst_n, start && !busy, out_strobe)
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_strobe, !out_strobe)
  `ASSERT_IMPLIES(a_count_bound, clk, rst_n, out_strobe, out_data.entry_count <= CNT_W'(TABLE_DEPTH))
  `ASSERT_IMPLIES(a_match_is_done, clk, rst_n, out_strobe && out_data.exact_match, out_data.status == ST_DONE)

endmodule

bind sorted_set_insert_and_rank ssir_checker u_ssir_checker (.*);
